@@ src/circq_pkg.sv @@
// circq_pkg: shared types and constants for the circular queue block.
// Operation codes, status codes and the result word layout.
// No dependencies.
package circq_pkg;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_RR  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CAP_W = 7;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [VAL_W-1:0] head_value;
    status_e                 status;
    logic                    job_finished;
    logic signed [VAL_W-1:0] requeued_value;
    logic [CAP_W-1:0]        count;
    logic                    is_empty;
    logic                    is_full;
  } res_t;

endpackage

@@ src/circq_op_if.sv @@
// circq_op_if: operation channel (valid/ready plus one operation word).
// Depends on nothing.
interface circq_op_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

@@ src/circq_res_if.sv @@
// circq_res_if: result channel (valid/ready plus one result word).
// Depends on circq_pkg for the status type.
interface circq_res_if;
  logic                 valid;
  logic                 ready;
  logic signed [31:0]   head_value;
  circq_pkg::status_e   status;
  logic                 job_finished;
  logic signed [31:0]   requeued_value;
  logic [6:0]           count;
  logic                 is_empty;
  logic                 is_full;

  modport source (output valid, output head_value, output status, output job_finished,
                  output requeued_value, output count, output is_empty, output is_full,
                  input ready);
  modport sink (input valid, input head_value, input status, input job_finished,
                input requeued_value, input count, input is_empty, input is_full,
                output ready);
endinterface

@@ src/circq_cfg_if.sv @@
// circq_cfg_if: configuration write channel for the queue capacity register.
// Depends on nothing.
interface circq_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] queue_capacity;

  modport source (output valid, output queue_capacity, input ready);
  modport sink (input valid, input queue_capacity, output ready);
endinterface

@@ src/circq_ram.sv @@
// circq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module circq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ src/circq_core.sv @@
// circq_core: queue state, capacity register and combinational operation logic.
// Depends on circq_pkg and circq_ram. Head value is cached; RAM read prefetches
// the next head after a pop.
module circq_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [circq_pkg::CAP_W-1:0]    cfg_cap_i,
  input  logic                           op_en_i,
  input  logic [1:0]                     op_mode_i,
  input  logic signed [circq_pkg::VAL_W-1:0] op_value_i,
  output circq_pkg::res_t                res_o
);
  import circq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = CW + 1;

  logic [CAP_W-1:0] cap_q;
  logic [AW-1:0]    head_idx_q, head_idx_d;
  logic [AW-1:0]    tail_idx_q, tail_idx_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [VAL_W-1:0] head_val_q, head_val_d;
  logic             use_ram_q, use_ram_d;

  logic [CW-1:0]    cap_eff;
  logic [VAL_W-1:0] cur_head;
  logic [VAL_W-1:0] ram_rdata;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VAL_W-1:0] ram_wdata;

  logic             pop_last;
  logic [AW-1:0]    head_nxt, tail_nxt;
  logic [VAL_W:0]   diff;
  logic             rr_fin;
  logic [VAL_W-1:0] rr_rem;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i, input logic [CW-1:0] c);
    logic [NW-1:0] s;
    s = NW'(i) + NW'(1);
    return (s >= NW'(c)) ? '0 : AW'(s);
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > DEPTH) begin
      cap_eff = CW'(DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign cur_head = use_ram_q ? ram_rdata : head_val_q;
  assign pop_last = (cnt_q == CW'(1));
  assign head_nxt = wrap_inc(head_idx_q, cap_eff);
  assign tail_nxt = wrap_inc(tail_idx_q, cap_eff);
  assign diff     = {cur_head[VAL_W-1], cur_head} - {op_value_i[VAL_W-1], op_value_i};
  assign rr_fin   = diff[VAL_W];
  assign rr_rem   = diff[VAL_W-1] ? VAL_MAX : diff[VAL_W-1:0];

  always_comb begin
    head_idx_d = head_idx_q;
    tail_idx_d = tail_idx_q;
    cnt_d      = cnt_q;
    head_val_d = cur_head;
    use_ram_d  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = op_value_i;
    ram_re     = 1'b0;
    ram_raddr  = head_nxt;
    res_o.head_value     = '0;
    res_o.status         = ST_DONE;
    res_o.job_finished   = 1'b0;
    res_o.requeued_value = '0;

    case (mode_e'(op_mode_i))
      MODE_ENQ: begin
        if (cnt_q >= cap_eff) begin
          res_o.status = ST_FULL;
        end else begin
          ram_we = op_en_i;
          cnt_d  = cnt_q + CW'(1);
          if (cnt_q == '0) begin
            head_idx_d = '0;
            tail_idx_d = '0;
            ram_waddr  = '0;
            head_val_d = op_value_i;
          end else begin
            tail_idx_d = tail_nxt;
            ram_waddr  = tail_nxt;
          end
        end
      end
      MODE_DEQ, MODE_RR: begin
        if (cnt_q == '0) begin
          res_o.status = ST_EMPTY;
        end else begin
          res_o.head_value = cur_head;
          if (mode_e'(op_mode_i) == MODE_DEQ || rr_fin) begin
            res_o.job_finished = (mode_e'(op_mode_i) == MODE_RR);
            cnt_d = cnt_q - CW'(1);
            if (pop_last) begin
              head_idx_d = '0;
              tail_idx_d = '0;
            end else begin
              head_idx_d = head_nxt;
              ram_re     = op_en_i;
              use_ram_d  = op_en_i;
            end
          end else begin
            res_o.requeued_value = rr_rem;
            ram_we    = op_en_i;
            ram_wdata = rr_rem;
            if (pop_last) begin
              head_idx_d = '0;
              tail_idx_d = '0;
              ram_waddr  = '0;
              head_val_d = rr_rem;
            end else begin
              head_idx_d = head_nxt;
              tail_idx_d = tail_nxt;
              ram_waddr  = tail_nxt;
              ram_re     = op_en_i;
              use_ram_d  = op_en_i;
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_o.count    = CAP_W'(cnt_d);
    res_o.is_empty = (cnt_d == '0);
    res_o.is_full  = (cnt_d == cap_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q      <= CAP_RESET;
      head_idx_q <= '0;
      tail_idx_q <= '0;
      cnt_q      <= '0;
      use_ram_q  <= 1'b0;
    end else begin
      use_ram_q <= use_ram_d;
      if (cfg_we_i) begin
        cap_q      <= cfg_cap_i;
        head_idx_q <= '0;
        tail_idx_q <= '0;
        cnt_q      <= '0;
      end else if (op_en_i) begin
        head_idx_q <= head_idx_d;
        tail_idx_q <= tail_idx_d;
        cnt_q      <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_en_i) begin
      head_val_q <= head_val_d;
    end else begin
      head_val_q <= cur_head;
    end
  end

  circq_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );
endmodule

@@ src/circular_queue_round_robin.sv @@
// circular_queue_round_robin: circular queue of signed 32-bit job times with
// enqueue, dequeue and round-robin time slice operations.
// Depends on circq_pkg, circq_op_if, circq_res_if, circq_cfg_if, circq_core.
//
// Usage:
//   op_i  : one word per operation (mode, value). Enqueue, dequeue or one
//           round-robin step with value as the quantum.
//   res_o : one word per operation: removed head, status, finished flag,
//           requeued remainder, count and empty/full flags after the op.
//   cfg_i : writes queue_capacity (clamped to 1..DEPTH); also empties the
//           queue. Always ready; write only while no operation is pending.
// Flow: an accepted word sits in the input register, is executed once the output
//   register is free or being taken, and its result is loaded into the output
//   register, which raises res_o.valid.
// Throughput: one operation per cycle while res_o is taken, set by the head/tail
//   update with one slot write and one head prefetch read per cycle.
// Reset: capacity 64, queue empty, no word pending on either side.
// Stall: when res_o is not taken the result holds, the input register fills,
//   then op_i.ready drops; nothing is lost or repeated.
module circular_queue_round_robin #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  circq_op_if.sink  op_i,
  circq_cfg_if.sink cfg_i,
  circq_res_if.source res_o
);
  import circq_pkg::*;

  logic                    in_valid_q;
  logic [1:0]              in_mode_q;
  logic signed [VAL_W-1:0] in_value_q;
  logic                    res_valid_q;
  res_t                    res_q;
  res_t                    core_res;
  logic                    exec;

  assign exec        = in_valid_q & (~res_valid_q | res_o.ready);
  assign op_i.ready  = ~in_valid_q | exec;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (op_i.ready) begin
        in_valid_q <= op_i.valid;
      end
      if (exec) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i.ready && op_i.valid) begin
      in_mode_q  <= op_i.mode;
      in_value_q <= op_i.value;
    end
    if (exec) begin
      res_q <= core_res;
    end
  end

  circq_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_i.valid),
    .cfg_cap_i (cfg_i.queue_capacity),
    .op_en_i   (exec),
    .op_mode_i (in_mode_q),
    .op_value_i(in_value_q),
    .res_o     (core_res)
  );

  assign res_o.valid          = res_valid_q;
  assign res_o.head_value     = res_q.head_value;
  assign res_o.status         = res_q.status;
  assign res_o.job_finished   = res_q.job_finished;
  assign res_o.requeued_value = res_q.requeued_value;
  assign res_o.count          = res_q.count;
  assign res_o.is_empty       = res_q.is_empty;
  assign res_o.is_full        = res_q.is_full;
endmodule

@@ test/circular_queue_round_robin_test.sv @@
// circular_queue_round_robin_test: self-checking bench for the round-robin job queue.
// Drives operation words and capacity writes, predicts every result word in-bench.
// Depends on circq_pkg, circq_op_if, circq_res_if, circq_cfg_if and the block itself.
module circular_queue_round_robin_test;
  timeunit 1ns;
  timeprecision 1ps;

  import circq_pkg::*;

  localparam int unsigned DEPTH = 64;
  localparam logic [1:0] MODE_IDLE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned HOLD_CYCLES = 100;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] value;
  } job_op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  circq_op_if op_if();
  circq_cfg_if cfg_if();
  circq_res_if res_if();

  circular_queue_round_robin #(.DEPTH(DEPTH)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .op_i  (op_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // queue model
  logic [6:0]  cap_reg;
  logic [31:0] slot_mem [DEPTH];
  int unsigned head_ix;
  int unsigned tail_ix;
  bit          q_empty;

  job_op_t pending_ops[$];
  res_t    expected_results[$];

  bit op_taken;
  bit steady;
  int hold_requests;
  int holds_done;
  int unsigned hold_left;
  int unsigned cycle_count;
  int error_count;
  int n_ops, n_checked, n_finished, n_requeued, n_rejected, n_cap_writes;

  function automatic int unsigned eff_capacity();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return cap_reg;
  endfunction

  function automatic int unsigned next_slot(int unsigned ix);
    return (ix + 1 >= eff_capacity()) ? 0 : ix + 1;
  endfunction

  function automatic int unsigned held_count();
    int unsigned c;
    c = eff_capacity();
    if (q_empty) return 0;
    return ((tail_ix + c - head_ix) % c) + 1;
  endfunction

  function automatic void clear_jobs();
    head_ix = 0;
    tail_ix = 0;
    q_empty = 1'b1;
  endfunction

  function automatic void push_job(logic [31:0] v);
    if (q_empty) begin
      head_ix = 0;
      tail_ix = 0;
      q_empty = 1'b0;
    end else begin
      tail_ix = next_slot(tail_ix);
    end
    slot_mem[tail_ix] = v;
  endfunction

  function automatic logic [31:0] pop_job();
    logic [31:0] v;
    v = slot_mem[head_ix];
    if (head_ix == tail_ix) clear_jobs();
    else head_ix = next_slot(head_ix);
    return v;
  endfunction

  function automatic res_t apply_op(logic [1:0] mode, logic [31:0] value);
    res_t r;
    longint h;
    longint q;
    longint rem;
    int unsigned n;
    r = '0;
    r.status = ST_DONE;
    case (mode)
      MODE_ENQ: begin
        if (held_count() >= eff_capacity()) r.status = ST_FULL;
        else push_job(value);
      end
      MODE_DEQ: begin
        if (q_empty) r.status = ST_EMPTY;
        else r.head_value = pop_job();
      end
      MODE_RR: begin
        if (q_empty) begin
          r.status = ST_EMPTY;
        end else begin
          h = $signed(slot_mem[head_ix]);
          q = $signed(value);
          r.head_value = pop_job();
          if (h < q) begin
            r.job_finished = 1'b1;
          end else begin
            rem = h - q;
            if (rem > 64'sd2147483647) rem = 64'sd2147483647;
            r.requeued_value = rem[31:0];
            push_job(rem[31:0]);
          end
        end
      end
      default: ;
    endcase
    n = held_count();
    r.count = n[6:0];
    r.is_empty = (n == 0);
    r.is_full = (n == eff_capacity());
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic void check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      error_count++;
      $display("%0t: result word with nothing expected, actual count %0d", $time,
               res_if.count);
      return;
    end
    want = expected_results.pop_front();
    compare_field("head_value", want.head_value, res_if.head_value);
    compare_field("status", want.status, res_if.status);
    compare_field("job_finished", want.job_finished, res_if.job_finished);
    compare_field("requeued_value", want.requeued_value, res_if.requeued_value);
    compare_field("count", want.count, res_if.count);
    compare_field("is_empty", want.is_empty, res_if.is_empty);
    compare_field("is_full", want.is_full, res_if.is_full);
    n_checked++;
  endfunction

  // monitor: everything is sampled at the rising edge
  always @(posedge clk_i) begin
    res_t r;
    if (rst_ni) begin
      op_taken <= op_if.valid && op_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        cap_reg = cfg_if.queue_capacity;
        clear_jobs();
        n_cap_writes++;
      end
      if (op_if.valid && op_if.ready) begin
        r = apply_op(op_if.mode, op_if.value);
        expected_results.push_back(r);
        n_ops++;
        if (r.job_finished) n_finished++;
        if (r.status == ST_DONE && op_if.mode == MODE_RR && !r.job_finished) n_requeued++;
        if (r.status != ST_DONE) n_rejected++;
      end
      if (res_if.valid && res_if.ready) check_result();
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // driver: one word on offer at a time, changed at the falling edge
  always @(negedge clk_i) begin
    job_op_t op;
    if (rst_ni && (!op_if.valid || op_taken)) begin
      if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        op = pending_ops.pop_front();
        op_if.mode <= op.mode;
        op_if.value <= op.value;
        op_if.valid <= 1'b1;
      end else begin
        op_if.valid <= 1'b0;
      end
    end
  end

  // receiver: random back-pressure plus long hold-offs on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (holds_done != hold_requests) begin
        holds_done <= holds_done + 1;
        hold_left <= HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= steady || ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic add_op(logic [1:0] mode, logic [31:0] value);
    job_op_t op;
    op.mode = mode;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  task automatic wait_drain();
    while (pending_ops.size() != 0 || op_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [6:0] cap);
    @(negedge clk_i);
    cfg_if.queue_capacity <= cap;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic job_op_t random_op(int unsigned enq_pct);
    job_op_t op;
    int unsigned roll;
    int unsigned pick;
    roll = $urandom_range(99);
    if (roll < 3) op.mode = MODE_IDLE;
    else if (roll < 3 + enq_pct) op.mode = MODE_ENQ;
    else if (roll < 3 + enq_pct + (97 - enq_pct) / 3) op.mode = MODE_DEQ;
    else op.mode = MODE_RR;
    pick = $urandom_range(9);
    case (pick)
      0: op.value = $urandom;
      1: begin
        case ($urandom_range(3))
          0: op.value = 32'h7FFF_FFFF;
          1: op.value = 32'h8000_0000;
          2: op.value = 32'h0000_0000;
          default: op.value = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        if (op.mode == MODE_RR) op.value = $urandom_range(400);
        else op.value = $urandom_range(1000, 1);
      end
    endcase
    return op;
  endfunction

  task automatic run_phase(logic [6:0] cap, int items, int unsigned enq_pct);
    write_capacity(cap);
    for (int i = 0; i < items; i++) pending_ops.push_back(random_op(enq_pct));
    wait_drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    op_if.valid = 1'b0;
    op_if.mode = MODE_ENQ;
    op_if.value = '0;
    cfg_if.valid = 1'b0;
    cfg_if.queue_capacity = '0;
    res_if.ready = 1'b0;
    cap_reg = CAP_RESET;
    clear_jobs();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty queue, reset capacity
    add_op(MODE_DEQ, 32'd0);
    add_op(MODE_RR, 32'd5);
    add_op(MODE_IDLE, 32'hFFFF_FFFF);
    add_op(MODE_ENQ, 32'h7FFF_FFFF);
    add_op(MODE_ENQ, 32'h8000_0000);
    add_op(MODE_ENQ, 32'd0);
    add_op(MODE_ENQ, 32'hFFFF_FFFF);
    // saturating remainder, then a finished job, then a zero remainder
    add_op(MODE_RR, 32'h8000_0000);
    add_op(MODE_RR, 32'h7FFF_FFFF);
    add_op(MODE_RR, 32'd0);
    add_op(MODE_IDLE, 32'd7);
    add_op(MODE_DEQ, 32'd0);
    add_op(MODE_DEQ, 32'd0);
    add_op(MODE_DEQ, 32'd0);
    add_op(MODE_DEQ, 32'd0);
    wait_drain();
    write_capacity(7'd2);
    add_op(MODE_ENQ, 32'd10);
    add_op(MODE_ENQ, 32'd3);
    add_op(MODE_ENQ, 32'd99);
    add_op(MODE_RR, 32'd4);
    add_op(MODE_DEQ, 32'd0);
    add_op(MODE_DEQ, 32'd0);
    add_op(MODE_DEQ, 32'd0);
    wait_drain();
    write_capacity(7'd0);
    add_op(MODE_ENQ, 32'd20);
    add_op(MODE_ENQ, 32'd21);
    add_op(MODE_RR, 32'd8);
    add_op(MODE_RR, 32'd13);
    wait_drain();

    // deep queue with a long hold-off on the result side
    write_capacity(7'd64);
    hold_requests = hold_requests + 1;
    for (int i = 0; i < 80; i++) pending_ops.push_back(random_op(55));
    wait_drain();
    run_phase(7'd127, 60, 45);
    run_phase(7'd3, 60, 40);
    run_phase(7'd1, 40, 40);
    run_phase(7'd0, 40, 40);
    steady = 1'b1;
    run_phase(7'd17, 70, 50);
    steady = 1'b0;
    run_phase(7'd2, 50, 40);
    run_phase(7'd100, 60, 60);
    run_phase(7'd8, 70, 35);
    run_phase(7'd5, 70, 45);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d operations over %0d capacity writes, %0d results checked.",
             n_ops, n_cap_writes, n_checked);
    $display("Jobs finished %0d, remainders requeued %0d, rejected operations %0d.",
             n_finished, n_requeued, n_rejected);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ circular_queue_round_robin.f @@
src/circq_pkg.sv
src/circq_op_if.sv
src/circq_res_if.sv
src/circq_cfg_if.sv
src/circq_ram.sv
src/circq_core.sv
src/circular_queue_round_robin.sv
test/circular_queue_round_robin_test.sv
